### hw/rtl/uv_sphere_vertex_generator_defines.svh
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_defines
// Assertion macros shared by the sphere vertex generator.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define UVS_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("uvs assertion failed");

// Check that a condition implies another in the following cycle
`define UVS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("uvs assertion failed");

`endif

### hw/rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Types, constants and helpers of the sphere vertex generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uvs_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_SECTORS = 2'd1;
    localparam logic [1:0] REG_STACKS  = 2'd2;

    // Odd polynomial for sin(pi/2 * u), Q30
    localparam logic [31:0] K1 = 32'd1686629713;
    localparam logic [31:0] K3 = 32'd693598668;
    localparam logic [31:0] K5 = 32'd85569306;
    localparam logic [31:0] K7 = 32'd5026995;
    localparam logic [31:0] K9 = 32'd172272;

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // Index data that rides beside the trig datapath
    typedef struct packed {
        logic [20:0] vertex;
        logic        quad;
        logic [20:0] first;
        logic [20:0] second;
    } side_t;

    // Shift right by n, rounding half away from zero
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int n);
        logic [63:0] mag;
        logic [63:0] res;
        mag = v[63] ? (64'd0 - 64'(v)) : 64'(v);
        res = (mag + (64'd1 << (n - 1))) >> n;
        return v[63] ? -$signed(res) : $signed(res);
    endfunction

endpackage

### hw/rtl/uvs_divider.sv
// ----------------------------------------------------------------------------
// uvs_divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uvs_divider #(
    parameter int NW = 32,
    parameter int DW = 11,
    parameter int QB = 21
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QB-1:0] quo
);

    logic [DW-1:0] rem_reg [QB];
    logic [QB-1:0] low_reg [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_stage
            logic [DW-1:0] rem_in;
            logic [QB-1:0] low_in;
            logic [DW:0]   trial;
            logic          take;

            // Upper numerator bits seed the remainder; they stay below den
            if (k == 0)
            begin : g_first
                assign rem_in = DW'(num >> QB);
                assign low_in = num[QB-1:0];
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign low_in = low_reg[k-1];
            end

            // Bring down one bit and subtract where it fits
            assign trial = {rem_in, low_in[QB-1]};
            assign take  = (trial >= {1'b0, den});

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= take ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
                low_reg[k] <= {low_in[QB-2:0], take};
            end
        end
    endgenerate

    assign quo = low_reg[QB-1];

endmodule

### hw/rtl/uvs_sincos.sv
// ----------------------------------------------------------------------------
// uvs_sincos
// Pipelined sine and cosine of a 20-bit phase, Q2.30, seven stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uvs_sincos
    import uvs_pkg::*;
(
    input  logic               clk,
    input  logic [19:0]        phase,
    output logic signed [31:0] sin_q,
    output logic signed [31:0] cos_q
);

    logic [1:0]  quad_reg [6];
    logic [18:0] x_in     [2];
    logic [31:0] q_reg    [2];
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;

    // Offset within the quarter wave and its complement
    assign x_in[0] = {1'b0, phase[17:0]};
    assign x_in[1] = 19'(19'h40000 - {1'b0, phase[17:0]});

    // Carry the quadrant beside the polynomial
    always_ff @(posedge clk)
    begin
        quad_reg[0] <= phase[19:18];
        for (int k = 1; k < 6; k++)
        begin
            quad_reg[k] <= quad_reg[k-1];
        end
    end

    genvar l, h;
    generate
        for (l = 0; l < 2; l++)
        begin : g_lane
            logic [30:0] u2_reg [5];
            logic [18:0] x_reg  [5];
            logic [31:0] p_reg  [4];
            logic [37:0] sq;
            logic [50:0] fin;

            // Square of the offset, Q30
            assign sq = x_in[l] * x_in[l];
            always_ff @(posedge clk)
            begin
                u2_reg[0] <= sq[36:6];
                x_reg[0]  <= x_in[l];
            end

            // Horner steps on the square
            for (h = 0; h < 4; h++)
            begin : g_horner
                logic [31:0] p_in;
                logic [31:0] k_c;
                logic [62:0] prod;
                if (h == 0)
                begin : g_p0
                    assign p_in = K9;
                end
                else
                begin : g_pn
                    assign p_in = p_reg[h-1];
                end
                assign k_c  = (h == 0) ? K7 : (h == 1) ? K5 : (h == 2) ? K3 : K1;
                assign prod = u2_reg[h] * p_in;
                always_ff @(posedge clk)
                begin
                    p_reg[h]    <= k_c - prod[61:30];
                    u2_reg[h+1] <= u2_reg[h];
                    x_reg[h+1]  <= x_reg[h];
                end
            end

            // Final odd factor and clamp to one
            assign fin = x_reg[4] * p_reg[3];
            always_ff @(posedge clk)
            begin
                if (fin[50:18] > {1'b0, ONE_Q30})
                begin
                    q_reg[l] <= ONE_Q30;
                end
                else
                begin
                    q_reg[l] <= fin[49:18];
                end
            end
        end
    endgenerate

    // Fold the quarter wave out to the full turn
    always_ff @(posedge clk)
    begin
        case (quad_reg[5])
            2'd0:
            begin
                sin_reg <= $signed(q_reg[0]);
                cos_reg <= $signed(q_reg[1]);
            end
            2'd1:
            begin
                sin_reg <= $signed(q_reg[1]);
                cos_reg <= -$signed(q_reg[0]);
            end
            2'd2:
            begin
                sin_reg <= -$signed(q_reg[0]);
                cos_reg <= -$signed(q_reg[1]);
            end
            default:
            begin
                sin_reg <= -$signed(q_reg[1]);
                cos_reg <= $signed(q_reg[0]);
            end
        endcase
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

### hw/rtl/uv_sphere_vertex_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Vertex, normal, texture and index words for points of a UV sphere.
// ----------------------------------------------------------------------------
// The block takes one grid point in every clock cycle (busy stays low) and
// gives its result word with done high for one cycle; results leave in
// order and cannot be held off. Each point passes the input register, the
// 21-stage angle dividers, the 7-stage sine and cosine pipeline and four
// multiply and round stages. The user must change the configuration only
// while no point is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps

`include "uv_sphere_vertex_generator_defines.svh"

module uv_sphere_vertex_generator
    import uvs_pkg::*;
#(
    parameter int MAX_SECTORS = 1024,
    parameter int MAX_STACKS  = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [10:0]        stack_index,
    input  logic [10:0]        sector_index,
    output logic               done,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic [16:0]        tex_s,
    output logic [16:0]        tex_t,
    output logic [20:0]        vertex_number,
    output logic               quad_valid,
    output logic [20:0]        first_corner,
    output logic [20:0]        second_corner
);

    localparam int LAST    = 32;
    localparam int LATENCY = LAST + 1;
    localparam int SIDE_D  = LAST - 1;
    localparam int TEX_D   = LAST - 21;

    function automatic logic [10:0] clamp_count(input logic [10:0] v, input int mx);
        if (v == 11'd0)
        begin
            return 11'd1;
        end
        if (int'(v) > mx)
        begin
            return 11'(mx);
        end
        return v;
    endfunction

    logic [15:0] radius_reg;
    logic [10:0] sectors_reg;
    logic [10:0] stacks_reg;
    logic [10:0] sec_c;
    logic [10:0] stk_c;
    logic        accept;

    logic        vld_reg [LAST+1];
    logic [10:0] i_reg;
    logic [10:0] j_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= 16'd256;
            sectors_reg <= 11'd36;
            stacks_reg  <= 11'd18;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS:  radius_reg  <= cfg_data;
                REG_SECTORS: sectors_reg <= cfg_data[10:0];
                REG_STACKS:  stacks_reg  <= cfg_data[10:0];
                default:     ;
            endcase
        end
    end

    assign sec_c  = clamp_count(sectors_reg, MAX_SECTORS);
    assign stk_c  = clamp_count(stacks_reg, MAX_STACKS);
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Valid bit travels with each word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int k = 1; k <= LAST; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Capture clamped indices
    always_ff @(posedge clk)
    begin
        i_reg <= (stack_index > stk_c) ? stk_c : stack_index;
        j_reg <= (sector_index > sec_c) ? sec_c : sector_index;
    end

    // Angle phases and texture coordinates by division
    logic [31:0] se_num, st_num, ts_num, tt_num;
    logic [20:0] se_q, st_q, ts_q, tt_q;

    assign se_num = 32'({j_reg, 20'b0}) + 32'(sec_c >> 1);
    assign st_num = 32'({i_reg, 19'b0}) + 32'(stk_c >> 1);
    assign ts_num = 32'({j_reg, 16'b0}) + 32'(sec_c >> 1);
    assign tt_num = 32'({i_reg, 16'b0}) + 32'(stk_c >> 1);

    uvs_divider #(.NW(32), .DW(11), .QB(21)) u_div_se
        (.clk(clk), .num(se_num), .den(sec_c), .quo(se_q));
    uvs_divider #(.NW(32), .DW(11), .QB(21)) u_div_st
        (.clk(clk), .num(st_num), .den(stk_c), .quo(st_q));
    uvs_divider #(.NW(32), .DW(11), .QB(21)) u_div_ts
        (.clk(clk), .num(ts_num), .den(sec_c), .quo(ts_q));
    uvs_divider #(.NW(32), .DW(11), .QB(21)) u_div_tt
        (.clk(clk), .num(tt_num), .den(stk_c), .quo(tt_q));

    // Sine and cosine of both angles
    logic signed [31:0] sa, ca, ss, cs;

    uvs_sincos u_trig_st (.clk(clk), .phase(st_q[19:0]), .sin_q(sa), .cos_q(ca));
    uvs_sincos u_trig_se (.clk(clk), .phase(se_q[19:0]), .sin_q(ss), .cos_q(cs));

    // Unit direction products
    logic signed [63:0] px_reg, pz_reg;
    logic signed [31:0] ny1_reg;
    always_ff @(posedge clk)
    begin
        px_reg  <= 64'(sa) * 64'(cs);
        pz_reg  <= 64'(sa) * 64'(ss);
        ny1_reg <= ca;
    end

    // Round the direction back to Q30
    logic signed [31:0] nx_reg, ny_reg, nz_reg;
    logic signed [63:0] rx, rz;
    assign rx = round_shift(px_reg, 30);
    assign rz = round_shift(pz_reg, 30);
    always_ff @(posedge clk)
    begin
        nx_reg <= rx[31:0];
        nz_reg <= 32'(-rz);
        ny_reg <= ny1_reg;
    end

    // Scale by the radius and round the normals
    logic signed [48:0] qx_reg, qy_reg, qz_reg;
    logic signed [15:0] nrx_reg, nry_reg, nrz_reg;
    logic signed [16:0] r_s;
    logic signed [63:0] gx, gy, gz;
    assign r_s = $signed({1'b0, radius_reg});
    assign gx  = round_shift(64'(nx_reg), 16);
    assign gy  = round_shift(64'(ny_reg), 16);
    assign gz  = round_shift(64'(nz_reg), 16);
    always_ff @(posedge clk)
    begin
        qx_reg  <= 49'(r_s) * 49'(nx_reg);
        qy_reg  <= 49'(r_s) * 49'(ny_reg);
        qz_reg  <= 49'(r_s) * 49'(nz_reg);
        nrx_reg <= gx[15:0];
        nry_reg <= gy[15:0];
        nrz_reg <= gz[15:0];
    end

    // Output register for the positions and normals
    logic signed [63:0] hx, hy, hz;
    assign hx = round_shift(64'(qx_reg), 30);
    assign hy = round_shift(64'(qy_reg), 30);
    assign hz = round_shift(64'(qz_reg), 30);
    always_ff @(posedge clk)
    begin
        pos_x    <= hx[16:0];
        pos_y    <= hy[16:0];
        pos_z    <= hz[16:0];
        normal_x <= nrx_reg;
        normal_y <= nry_reg;
        normal_z <= nrz_reg;
    end

    // Hold the texture coordinates until the trig path catches up
    logic [16:0] ts_dly [TEX_D];
    logic [16:0] tt_dly [TEX_D];
    always_ff @(posedge clk)
    begin
        ts_dly[0] <= ts_q[16:0];
        tt_dly[0] <= tt_q[16:0];
        for (int k = 1; k < TEX_D; k++)
        begin
            ts_dly[k] <= ts_dly[k-1];
            tt_dly[k] <= tt_dly[k-1];
        end
    end

    // Vertex and corner indices
    logic [23:0] vn_reg;
    logic        quad1_reg;
    logic [10:0] sec1_reg;
    side_t       side_dly [SIDE_D];
    logic [23:0] vn_sum;

    always_ff @(posedge clk)
    begin
        vn_reg    <= 24'(i_reg * ({1'b0, sec_c} + 12'd1)) + 24'(j_reg);
        quad1_reg <= (i_reg < stk_c) && (j_reg < sec_c);
        sec1_reg  <= sec_c;
    end

    assign vn_sum = vn_reg + 24'(sec1_reg) + 24'd1;

    always_ff @(posedge clk)
    begin
        side_dly[0].vertex <= vn_reg[20:0];
        side_dly[0].quad   <= quad1_reg;
        side_dly[0].first  <= quad1_reg ? vn_reg[20:0] : 21'd0;
        side_dly[0].second <= quad1_reg ? vn_sum[20:0] : 21'd0;
        for (int k = 1; k < SIDE_D; k++)
        begin
            side_dly[k] <= side_dly[k-1];
        end
    end

    assign done          = vld_reg[LAST];
    assign tex_s         = ts_dly[TEX_D-1];
    assign tex_t         = tt_dly[TEX_D-1];
    assign vertex_number = side_dly[SIDE_D-1].vertex;
    assign quad_valid    = side_dly[SIDE_D-1].quad;
    assign first_corner  = side_dly[SIDE_D-1].first;
    assign second_corner = side_dly[SIDE_D-1].second;

    // Every result word comes from a point taken a fixed time before
    `UVS_ASSERT_IMPL(a_done_latency, clk, rst_n, done, $past(accept, LATENCY))
    // Points outside the quad grid carry no corners
    `UVS_ASSERT_IMPL(a_no_corner, clk, rst_n, done && !quad_valid,
        first_corner == 21'd0 && second_corner == 21'd0)
    // A quad starts at its own vertex
    `UVS_ASSERT_IMPL(a_first_is_vertex, clk, rst_n, done && quad_valid,
        first_corner == vertex_number)

endmodule
